### rtl/pbrl_pkg.sv
// Shared types and constants of the point box region lookup block.
// No dependencies.
`default_nettype none
package pbrl_pkg;

  localparam int unsigned LABEL_W = 3;
  localparam int unsigned OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // one result item
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               hit;
    logic               full;
  } res_t;

endpackage
`default_nettype wire

### rtl/pbrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pbrl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/point_box_region_lookup.sv
// Top level of the point box region lookup block.
// Depends on pbrl_pkg and pbrl_ram.
//
// Keeps up to MAX_BOXES axis-aligned 3D boxes, each with a 3-bit region
// label, in one RAM word per box ({label, hi z/y/x, lo z/y/x}). An append
// orders each axis into low/high bounds and writes the box at the next free
// slot, or reports full_res when the table is full. A query reads the stored
// boxes one per cycle from slot 0 upward and returns the label of the first
// box holding the point (bounds inclusive), or default_label with hit low.
// A clear resets the fill count; the RAM itself is never swept. Append,
// clear, unused op codes and a query on an empty table go from input
// transfer straight to the result state; any other query first scans,
// reading k boxes where k is the position of the first hit plus one, or
// the fill count on a miss, through the single RAM read port with its
// registered read data. The next input transfer can be taken in the cycle
// after the result moves to the output register. A new item is taken while
// the previous result still waits in the output register. Coordinates are
// two's complement, 8 fraction bits.
`default_nettype none
module point_box_region_lookup #(
  parameter int unsigned MAX_BOXES  = 64,
  parameter int unsigned COORD_BITS = 22
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pbrl_pkg::OP_W-1:0]      op_i,
  input  wire logic signed [COORD_BITS-1:0]   ax_i,
  input  wire logic signed [COORD_BITS-1:0]   ay_i,
  input  wire logic signed [COORD_BITS-1:0]   az_i,
  input  wire logic signed [COORD_BITS-1:0]   bx_i,
  input  wire logic signed [COORD_BITS-1:0]   by_i,
  input  wire logic signed [COORD_BITS-1:0]   bz_i,
  input  wire logic [pbrl_pkg::LABEL_W-1:0]   label_in_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [pbrl_pkg::LABEL_W-1:0]        label_out_o,
  output logic                                hit_o,
  output logic                                full_res_o,
  // default_label register
  input  wire logic                           cfg_we_i,
  input  wire logic [pbrl_pkg::LABEL_W-1:0]   cfg_wdata_i
);

  localparam int unsigned IDX_W  = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int unsigned WORD_W = 6 * COORD_BITS + pbrl_pkg::LABEL_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RES  = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [CNT_W-1:0]             idx_q, idx_d;
  logic                         rd_pend_q, rd_pend_d;
  logic [pbrl_pkg::LABEL_W-1:0] dflt_q;
  pbrl_pkg::res_t               res_q, res_d;
  logic signed [COORD_BITS-1:0] px_q, py_q, pz_q;
  logic                         out_valid_q;
  pbrl_pkg::res_t               out_q;

  logic                         in_xfer, out_free;
  logic                         ram_we, ram_re;
  logic [WORD_W-1:0]            ram_wdata, ram_rdata;
  logic signed [COORD_BITS-1:0] lx, ly, lz, hx, hy, hz;
  logic signed [COORD_BITS-1:0] e_lx, e_ly, e_lz, e_hx, e_hy, e_hz;
  logic [pbrl_pkg::LABEL_W-1:0] e_label;
  logic                         match;
  logic                         tbl_full;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign tbl_full   = (cnt_q == CNT_W'(MAX_BOXES));

  // axis ordering for append
  assign lx = (ax_i < bx_i) ? ax_i : bx_i;
  assign hx = (ax_i < bx_i) ? bx_i : ax_i;
  assign ly = (ay_i < by_i) ? ay_i : by_i;
  assign hy = (ay_i < by_i) ? by_i : ay_i;
  assign lz = (az_i < bz_i) ? az_i : bz_i;
  assign hz = (az_i < bz_i) ? bz_i : az_i;

  assign ram_wdata = {label_in_i, hz, hy, hx, lz, ly, lx};
  assign ram_we    = in_xfer && (op_i == pbrl_pkg::OP_APPEND) && !tbl_full;
  // scan issues one read per cycle while slots remain
  assign ram_re    = (state_q == ST_SCAN) && (idx_q < cnt_q);

  pbrl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_BOXES)
  ) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // unpack the entry read last cycle
  assign e_lx    = $signed(ram_rdata[0*COORD_BITS +: COORD_BITS]);
  assign e_ly    = $signed(ram_rdata[1*COORD_BITS +: COORD_BITS]);
  assign e_lz    = $signed(ram_rdata[2*COORD_BITS +: COORD_BITS]);
  assign e_hx    = $signed(ram_rdata[3*COORD_BITS +: COORD_BITS]);
  assign e_hy    = $signed(ram_rdata[4*COORD_BITS +: COORD_BITS]);
  assign e_hz    = $signed(ram_rdata[5*COORD_BITS +: COORD_BITS]);
  assign e_label = ram_rdata[6*COORD_BITS +: pbrl_pkg::LABEL_W];

  assign match = (e_lx <= px_q) && (px_q <= e_hx) &&
                 (e_ly <= py_q) && (py_q <= e_hy) &&
                 (e_lz <= pz_q) && (pz_q <= e_hz);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    rd_pend_d = 1'b0;
    res_d     = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          res_d   = '0;
          state_d = ST_RES;
          unique case (pbrl_pkg::op_e'(op_i))
            pbrl_pkg::OP_APPEND: begin
              if (tbl_full) begin
                res_d.full = 1'b1;
              end else begin
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            pbrl_pkg::OP_QUERY: begin
              res_d.label = dflt_q;
              idx_d       = '0;
              if (cnt_q != '0) begin
                state_d = ST_SCAN;
              end
            end
            pbrl_pkg::OP_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (ram_re) begin
          idx_d     = idx_q + CNT_W'(1);
          rd_pend_d = 1'b1;
        end
        priority if (rd_pend_q && match) begin
          res_d.label = e_label;
          res_d.hit   = 1'b1;
          state_d     = ST_RES;
        end else if (rd_pend_q && !ram_re) begin
          // last slot read and missed: default label already set
          state_d = ST_RES;
        end else begin
        end
      end
      ST_RES: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      dflt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      rd_pend_q <= rd_pend_d;
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
      if (state_q == ST_RES && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_xfer && op_i == pbrl_pkg::OP_QUERY) begin
      px_q <= ax_i;
      py_q <= ay_i;
      pz_q <= az_i;
    end
    if (state_q == ST_RES && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign label_out_o = out_q.label;
  assign hit_o       = out_q.hit;
  assign full_res_o  = out_q.full;

  // fill count never passes the table size
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_BOXES))
    else $error("box count beyond table size");

  // scan index never passes the fill count
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> idx_q <= cnt_q)
    else $error("scan index past fill count");

  // a hit and a dropped append never come together
  a_res_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && full_res_o))
    else $error("hit and full both set");

  // leaving the result state loads the output register
  a_res_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RES && out_free) |=> (state_q == ST_IDLE && out_valid_q))
    else $error("result not loaded");

endmodule
`default_nettype wire

### tb/tb_point_box_region_lookup.sv
// Self-checking testbench for point_box_region_lookup: a directed table of
// transfers, then random phases, checked against hand-typed or model results.
// Depends on pbrl_pkg and the point_box_region_lookup RTL.
module tb_point_box_region_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  // package items used here
  localparam int unsigned LABEL_W = pbrl_pkg::LABEL_W;
  localparam int unsigned OP_W    = pbrl_pkg::OP_W;
  typedef pbrl_pkg::op_e  op_e;
  typedef pbrl_pkg::res_t res_t;
  localparam op_e OP_APPEND = pbrl_pkg::OP_APPEND;
  localparam op_e OP_QUERY  = pbrl_pkg::OP_QUERY;
  localparam op_e OP_CLEAR  = pbrl_pkg::OP_CLEAR;
  localparam op_e OP_NONE   = pbrl_pkg::OP_NONE;

  localparam int unsigned MAX_BOXES = 64;
  localparam int unsigned COORD_W   = 22;
  localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned NDIR = 24;

  // one input transfer
  typedef struct {
    op_e                        op;
    logic signed [COORD_W-1:0]  ax, ay, az, bx, by, bz;
    logic        [LABEL_W-1:0]  lbl;
  } item_t;

  // directed row: the transfer, how often to send it, and a hand-typed result
  // where one is obvious (otherwise the table model decides)
  typedef struct {
    item_t       it;
    int unsigned reps;
    bit          typed;
    res_t        want;
  } row_t;

  // result waiting to come out, tagged with the transfer number for messages
  typedef struct {
    res_t        res;
    int unsigned seq;
  } pending_t;

  // ---------------------------------------------------------------------------
  // clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  logic                       in_valid_i  = 1'b0;
  logic                       in_stall_o;
  logic [OP_W-1:0]            op_i        = OP_NONE;
  logic signed [COORD_W-1:0]  ax_i        = '0;
  logic signed [COORD_W-1:0]  ay_i        = '0;
  logic signed [COORD_W-1:0]  az_i        = '0;
  logic signed [COORD_W-1:0]  bx_i        = '0;
  logic signed [COORD_W-1:0]  by_i        = '0;
  logic signed [COORD_W-1:0]  bz_i        = '0;
  logic [LABEL_W-1:0]         label_in_i  = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [LABEL_W-1:0]         label_out_o;
  logic                       hit_o;
  logic                       full_res_o;
  logic                       cfg_we_i    = 1'b0;
  logic [LABEL_W-1:0]         cfg_wdata_i = '0;

  point_box_region_lookup #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_W)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .ax_i        (ax_i),
    .ay_i        (ay_i),
    .az_i        (az_i),
    .bx_i        (bx_i),
    .by_i        (by_i),
    .bz_i        (bz_i),
    .label_in_i  (label_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .label_out_o (label_out_o),
    .hit_o       (hit_o),
    .full_res_o  (full_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // ---------------------------------------------------------------------------
  // table model: own copy of the box store, fill count and default label
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] tbl_lo_x [MAX_BOXES];
  logic signed [COORD_W-1:0] tbl_lo_y [MAX_BOXES];
  logic signed [COORD_W-1:0] tbl_lo_z [MAX_BOXES];
  logic signed [COORD_W-1:0] tbl_hi_x [MAX_BOXES];
  logic signed [COORD_W-1:0] tbl_hi_y [MAX_BOXES];
  logic signed [COORD_W-1:0] tbl_hi_z [MAX_BOXES];
  logic [LABEL_W-1:0]        tbl_label [MAX_BOXES];
  int unsigned               tbl_count  = 0;
  logic [LABEL_W-1:0]        dflt_label = '0;

  pending_t    expected_lookups [$];
  int unsigned items_sent  = 0;
  int unsigned err_count   = 0;
  bit          burst_mode  = 1'b0;   // no gaps on either side
  int unsigned hold_cycles = 0;      // one-shot long hold-off for the sink

  // Apply one transfer to the table model and return the result it yields.
  function automatic res_t apply_to_table(input item_t it);
    res_t        r;
    int unsigned i;
    r = '0;
    case (it.op)
      OP_APPEND: begin
        if (tbl_count >= MAX_BOXES) begin
          r.full = 1'b1;
        end else begin
          // order each axis so the smaller corner is the low bound
          tbl_lo_x[tbl_count]  = (it.ax < it.bx) ? it.ax : it.bx;
          tbl_hi_x[tbl_count]  = (it.ax < it.bx) ? it.bx : it.ax;
          tbl_lo_y[tbl_count]  = (it.ay < it.by) ? it.ay : it.by;
          tbl_hi_y[tbl_count]  = (it.ay < it.by) ? it.by : it.ay;
          tbl_lo_z[tbl_count]  = (it.az < it.bz) ? it.az : it.bz;
          tbl_hi_z[tbl_count]  = (it.az < it.bz) ? it.bz : it.az;
          tbl_label[tbl_count] = it.lbl;
          tbl_count++;
        end
      end
      OP_QUERY: begin
        r.label = dflt_label;
        // lowest slot wins, bounds inclusive on all axes
        for (i = 0; i < tbl_count; i++) begin
          if (tbl_lo_x[i] <= it.ax && it.ax <= tbl_hi_x[i] &&
              tbl_lo_y[i] <= it.ay && it.ay <= tbl_hi_y[i] &&
              tbl_lo_z[i] <= it.az && it.az <= tbl_hi_z[i]) begin
            r.label = tbl_label[i];
            r.hit   = 1'b1;
            break;
          end
        end
      end
      OP_CLEAR: tbl_count = 0;
      default: ;  // unused code: all-zero result
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // random stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly a narrow window around zero so boxes overlap, with extremes and
  // full-width values so every coordinate bit toggles.
  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return CMIN;
      1:       return CMAX;
      2, 3, 4: return COORD_W'($urandom);
      default: return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // Coordinate on one axis of a stored box: inside, on a bound, or just past.
  function automatic logic signed [COORD_W-1:0] pick_axis(
    input logic signed [COORD_W-1:0] lo,
    input logic signed [COORD_W-1:0] hi
  );
    longint span;
    span = longint'(hi) - longint'(lo);
    case ($urandom_range(0, 15))
      0:       return lo;
      1:       return hi;
      2:       return COORD_W'(lo - 1);
      3:       return COORD_W'(hi + 1);
      default: return COORD_W'(longint'(lo) + longint'($urandom) % (span + 1));
    endcase
  endfunction

  // Well-formed traffic: appends and queries dominate, queries mostly aim at
  // a stored box; clears only when clear_pct is nonzero, a little unused-op
  // noise. Fields an op ignores always carry random bits.
  function automatic item_t random_item(input int unsigned clear_pct);
    item_t       it;
    int unsigned r;
    int unsigned s;
    it.ax  = rand_coord();
    it.ay  = rand_coord();
    it.az  = rand_coord();
    it.bx  = rand_coord();
    it.by  = rand_coord();
    it.bz  = rand_coord();
    it.lbl = LABEL_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < clear_pct) begin
      it.op = OP_CLEAR;
    end else if (r < clear_pct + 2) begin
      it.op = OP_NONE;
    end else if (r < 55) begin
      it.op = OP_APPEND;
    end else begin
      it.op = OP_QUERY;
      if (tbl_count > 0 && $urandom_range(0, 9) < 7) begin
        s = $urandom_range(0, tbl_count - 1);
        it.ax = pick_axis(tbl_lo_x[s], tbl_hi_x[s]);
        it.ay = pick_axis(tbl_lo_y[s], tbl_hi_y[s]);
        it.az = pick_axis(tbl_lo_z[s], tbl_hi_z[s]);
      end
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // Offer one transfer after a random gap and hold it until taken. valid is
  // only dropped when a gap is drawn, so it never toggles within one step.
  task automatic send_item(input item_t it, input bit typed, input res_t want);
    int unsigned gap;
    res_t        r;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= it.op;
    ax_i       <= it.ax;
    ay_i       <= it.ay;
    az_i       <= it.az;
    bx_i       <= it.bx;
    by_i       <= it.by;
    bz_i       <= it.bz;
    label_in_i <= it.lbl;
    do @(posedge clk_i); while (in_stall_o);
    // accepted at this edge: the model moves with the block
    r = apply_to_table(it);
    expected_lookups.push_back('{typed ? want : r, items_sent});
    items_sent++;
  endtask

  // Drop valid and wait until every outstanding result has been taken.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
  endtask

  // Only called with the block drained.
  task automatic write_default_label(input logic [LABEL_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    dflt_label   = value;
  endtask

  // ---------------------------------------------------------------------------
  // output side: random stall before every result, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned n;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = burst_mode ? 0 : $urandom_range(0, 3);
      end
      if (n > 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  // Compare every result transfer, field by field, with the oldest expectation.
  always @(posedge clk_i) begin
    pending_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lookups.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending (label %0d hit %b full %b)",
                                  label_out_o, hit_o, full_res_o));
      end else begin
        head = expected_lookups.pop_front();
        if (label_out_o !== head.res.label)
          report_mismatch($sformatf("item %0d label_out %0d, want %0d",
                                    head.seq, label_out_o, head.res.label));
        if (hit_o !== head.res.hit)
          report_mismatch($sformatf("item %0d hit %b, want %b",
                                    head.seq, hit_o, head.res.hit));
        if (full_res_o !== head.res.full)
          report_mismatch($sformatf("item %0d full_res %b, want %b",
                                    head.seq, full_res_o, head.res.full));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // directed table (default label is 0 throughout)
  // ---------------------------------------------------------------------------
  row_t dir_rows [NDIR] = '{
    // empty table right after reset: default label, no hit; b/label are noise
    '{'{OP_QUERY, 0, 0, 0, CMAX, CMIN, CMAX, 3'd7}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    // unused op code with every input bit set
    '{'{OP_NONE, -1, -1, -1, -1, -1, -1, 3'd7}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    '{'{OP_CLEAR, -1, -1, -1, -1, -1, -1, 3'd7}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    // whole coordinate space, corners given max-first on every axis
    '{'{OP_APPEND, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 3'd5}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    '{'{OP_QUERY, CMIN, CMIN, CMIN, 0, 0, 0, 3'd0}, 1, 1'b1, '{3'd5, 1'b1, 1'b0}},
    '{'{OP_QUERY, CMAX, CMAX, CMAX, 0, 0, 0, 3'd0}, 1, 1'b1, '{3'd5, 1'b1, 1'b0}},
    '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0, 3'd0}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    // cleared table misses everything
    '{'{OP_QUERY, 0, 0, 0, 0, 0, 0, 3'd0}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    // two overlapping boxes: the lower slot must win in the overlap
    '{'{OP_APPEND, 256, 256, 256, -256, -256, -256, 3'd3}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    '{'{OP_APPEND, 0, 0, 0, 512, 512, 512, 3'd6}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    '{'{OP_QUERY, 256, 256, 256, CMIN, CMAX, -1, 3'd7}, 1, 1'b0, '0},
    '{'{OP_QUERY, 257, 0, 512, 0, 0, 0, 3'd0}, 1, 1'b0, '0},
    '{'{OP_QUERY, -257, 0, 0, 0, 0, 0, 3'd0}, 1, 1'b0, '0},
    '{'{OP_QUERY, 0, -256, 513, 0, 0, 0, 3'd0}, 1, 1'b0, '0},
    // zero-volume box: only its exact point hits
    '{'{OP_APPEND, 1000, -1000, 7, 1000, -1000, 7, 3'd7}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    '{'{OP_QUERY, 1000, -1000, 7, 0, 0, 0, 3'd0}, 1, 1'b0, '0},
    '{'{OP_QUERY, 1000, -1000, 8, 0, 0, 0, 3'd0}, 1, 1'b0, '0},
    // fill up to the last slot with tiny boxes in the far corner
    '{'{OP_APPEND, CMIN, CMIN, CMIN, -2097151, -2097151, -2097151, 3'd2}, 60, 1'b0, '0},
    '{'{OP_APPEND, 2000, 2000, 2000, 2100, 2100, 2100, 3'd4}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    // table full: append dropped and flagged
    '{'{OP_APPEND, 0, 0, 0, 1, 1, 1, 3'd1}, 1, 1'b1, '{3'd0, 1'b0, 1'b1}},
    // hit in the last slot, then a miss after a full-length scan
    '{'{OP_QUERY, 2100, 2000, 2050, 0, 0, 0, 3'd0}, 1, 1'b0, '0},
    '{'{OP_QUERY, 5000, 5000, 5000, 0, 0, 0, 3'd0}, 1, 1'b0, '0},
    '{'{OP_CLEAR, 0, 0, 0, 0, 0, 0, 3'd0}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}},
    '{'{OP_QUERY, 2050, 2050, 2050, 0, 0, 0, 3'd0}, 1, 1'b1, '{3'd0, 1'b0, 1'b0}}
  };

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned ph;
    int unsigned k;
    int unsigned r;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      for (r = 0; r < dir_rows[i].reps; r++)
        send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases. Each starts drained, with a new default label (extremes
    // first). Every third phase has no clears so the table fills up; one
    // phase runs back to back, one starts with a long sink hold-off so the
    // block backs up into its input.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      write_default_label(ph == 0 ? 3'd7 : ph == 1 ? 3'd0 : LABEL_W'($urandom));
      burst_mode = (ph == 2);
      if (ph == 4) hold_cycles = 300;
      for (k = 0; k < PHASE_ITEMS; k++)
        send_item(random_item(ph % 3 == 0 ? 0 : 4), 1'b0, '0);
    end

    burst_mode = 1'b0;
    drain_results();
    // catch any stray result the block might still push out
    repeat (MAX_BOXES + 8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[point_box_region_lookup] OK");
    end else begin
      $display("[point_box_region_lookup] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[point_box_region_lookup] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/pbrl_pkg.sv
rtl/pbrl_ram.sv
rtl/point_box_region_lookup.sv
tb/tb_point_box_region_lookup.sv
